[hw/rtl/transformed_box_bounds_core_macros.svh]
// assertion macros for the transformed box bounds core
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef TRANSFORMED_BOX_BOUNDS_CORE_MACROS_SVH
`define TRANSFORMED_BOX_BOUNDS_CORE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define TBB_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("tbb assertion failed");

// condition holds in the cycle after the trigger
`define TBB_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("tbb assertion failed");

`endif

[hw/rtl/tbb_pkg.sv]
// shared types and constants for the transformed box bounds core
// no dependencies
package tbb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COEF_W          = 32;
    localparam int ORG_W           = 32;
    localparam int EXT_W           = 31;
    localparam int OUT_W           = 32;
    localparam int SPAN_W          = 31;
    localparam int QDEPTH          = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_BOX  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORNER,
        S_MUL,
        S_ACC,
        S_ROW,
        S_WCHK,
        S_RCP,
        S_RCPF,
        S_SMUL,
        S_SACC,
        S_BOUND,
        S_DONE
    } t_state;

    // one queued command
    typedef struct packed {
        t_op                        op;
        logic [3:0]                 idx;
        logic signed [COEF_W-1:0]   coef;
        logic signed [ORG_W-1:0]    org_x;
        logic signed [ORG_W-1:0]    org_y;
        logic signed [ORG_W-1:0]    org_z;
        logic [EXT_W-1:0]           ext_x;
        logic [EXT_W-1:0]           ext_y;
        logic [EXT_W-1:0]           ext_z;
    } t_cmd;

    // queue status toward the back end
    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_stat;

    // back end status
    typedef struct packed {
        logic busy;
        logic done;
    } t_back_stat;

endpackage

[hw/rtl/transformed_box_bounds_core.sv]
// top level of the transformed box bounds core
// depends on tbb_pkg, tbb_front, tbb_back and the macros header
//
//  channel   handshake                 payload
//  input     i_in_valid / o_in_ready   i_opcode, i_coef_*, i_origin_*, i_extent_*
//  output    o_out_valid / i_out_ready o_bound_x/y/z, o_bound_w/h/d
//
// a coefficient load is written to the matrix as the back end pops it; a box
// runs its eight corners in turn, each a matrix product and, for a corner whose
// w needs a reciprocal, the bit-serial reciprocal divider and a perspective
// scaling, with every product formed by the one shared multiplier.
// a two-entry command queue lets input transactions land while a box runs.
// reset is synchronous, active low, and restores the identity matrix.
// a finished result waits in the output register while the next command starts.
`include "transformed_box_bounds_core_macros.svh"

module transformed_box_bounds_core #(
    parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tbb_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [3:0]                        i_coef_index,
    input  logic signed [tbb_pkg::COEF_W-1:0] i_coef_value,
    input  logic signed [tbb_pkg::ORG_W-1:0]  i_origin_x,
    input  logic signed [tbb_pkg::ORG_W-1:0]  i_origin_y,
    input  logic signed [tbb_pkg::ORG_W-1:0]  i_origin_z,
    input  logic [tbb_pkg::EXT_W-1:0]         i_extent_x,
    input  logic [tbb_pkg::EXT_W-1:0]         i_extent_y,
    input  logic [tbb_pkg::EXT_W-1:0]         i_extent_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tbb_pkg::OUT_W-1:0]  o_bound_x,
    output logic signed [tbb_pkg::OUT_W-1:0]  o_bound_y,
    output logic signed [tbb_pkg::OUT_W-1:0]  o_bound_z,
    output logic [tbb_pkg::SPAN_W-1:0]        o_bound_w,
    output logic [tbb_pkg::SPAN_W-1:0]        o_bound_h,
    output logic [tbb_pkg::SPAN_W-1:0]        o_bound_d
);

    tbb_pkg::t_cmd       w_head;
    tbb_pkg::t_q_stat    w_q_stat;
    tbb_pkg::t_back_stat w_back_stat;
    logic                w_pop;

    // accept and queue
    tbb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_origin_z   (i_origin_z),
        .i_extent_x   (i_extent_x),
        .i_extent_y   (i_extent_y),
        .i_extent_z   (i_extent_z),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_stat       (w_q_stat)
    );

    // execute
    tbb_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_stat      (w_back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_bound_x   (o_bound_x),
        .o_bound_y   (o_bound_y),
        .o_bound_z   (o_bound_z),
        .o_bound_w   (o_bound_w),
        .o_bound_h   (o_bound_h),
        .o_bound_d   (o_bound_d)
    );

    // checks
    `TBB_ASSERT_NOW(a_pop_has_head, w_pop, w_q_stat.head_valid)
    `TBB_ASSERT_NOW(a_done_while_busy, w_back_stat.done, w_back_stat.busy)
    `TBB_ASSERT_NEXT(a_out_drains, o_out_valid && i_out_ready && !w_back_stat.done, !o_out_valid)

endmodule

[hw/rtl/tbb_front.sv]
// front end: accepts input transactions, classifies them, queues commands
// depends on tbb_pkg
module tbb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [3:0]                      i_coef_index,
    input  logic signed [tbb_pkg::COEF_W-1:0] i_coef_value,
    input  logic signed [tbb_pkg::ORG_W-1:0]  i_origin_x,
    input  logic signed [tbb_pkg::ORG_W-1:0]  i_origin_y,
    input  logic signed [tbb_pkg::ORG_W-1:0]  i_origin_z,
    input  logic [tbb_pkg::EXT_W-1:0]       i_extent_x,
    input  logic [tbb_pkg::EXT_W-1:0]       i_extent_y,
    input  logic [tbb_pkg::EXT_W-1:0]       i_extent_z,
    input  logic                            i_pop,
    output tbb_pkg::t_cmd                   o_head,
    output tbb_pkg::t_q_stat                o_stat
);

    tbb_pkg::t_cmd r_mem [tbb_pkg::QDEPTH];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_cnt;
    tbb_pkg::t_cmd w_cmd;
    logic          w_push;

    // classify: a load keeps only index and value, a box keeps its geometry
    always_comb begin
        w_cmd = '0;
        if (i_opcode == tbb_pkg::OP_BOX) begin
            w_cmd.op    = tbb_pkg::OP_BOX;
            w_cmd.org_x = i_origin_x;
            w_cmd.org_y = i_origin_y;
            w_cmd.org_z = i_origin_z;
            w_cmd.ext_x = i_extent_x;
            w_cmd.ext_y = i_extent_y;
            w_cmd.ext_z = i_extent_z;
        end else begin
            w_cmd.op   = tbb_pkg::OP_LOAD;
            w_cmd.idx  = i_coef_index;
            w_cmd.coef = i_coef_value;
        end
    end

    assign o_in_ready       = (r_cnt != 2'(tbb_pkg::QDEPTH));
    assign w_push           = i_in_valid && o_in_ready;
    assign o_head           = r_mem[r_rptr];
    assign o_stat.head_valid = (r_cnt != 2'd0);
    assign o_stat.full      = !o_in_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

[hw/rtl/tbb_back.sv]
// back end: matrix store, shared multiplier, reciprocal divider, bounds
// depends on tbb_pkg
module tbb_back #(
    parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tbb_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tbb_pkg::t_cmd                    i_head,
    input  tbb_pkg::t_q_stat                 i_q_stat,
    output logic                             o_pop,
    output tbb_pkg::t_back_stat              o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [tbb_pkg::OUT_W-1:0] o_bound_x,
    output logic signed [tbb_pkg::OUT_W-1:0] o_bound_y,
    output logic signed [tbb_pkg::OUT_W-1:0] o_bound_z,
    output logic [tbb_pkg::SPAN_W-1:0]       o_bound_w,
    output logic [tbb_pkg::SPAN_W-1:0]       o_bound_h,
    output logic [tbb_pkg::SPAN_W-1:0]       o_bound_d
);

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = (CW > tbb_pkg::COEF_W) ? CW : tbb_pkg::COEF_W;
    localparam int PW   = 2 * MW;
    localparam int AW   = PW + 2;
    localparam int DW   = 2 * FRAC_BITS + 1;
    localparam int CNTW = $clog2(DW + 1);
    localparam int SW   = (CW + 1 > tbb_pkg::OUT_W) ? CW + 1 : tbb_pkg::OUT_W;
    localparam int OW   = tbb_pkg::OUT_W;
    localparam int XW   = tbb_pkg::EXT_W;
    localparam int SPW  = tbb_pkg::SPAN_W;
    localparam logic signed [AW-1:0] L_HI  = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] L_LO  = ~L_HI;
    localparam logic signed [AW-1:0] L_ONE = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [SW-1:0] L_SPAN_MAX = {{(SW-SPW){1'b0}}, {SPW{1'b1}}};

    // clamp a wide value to the coordinate range
    function automatic logic signed [CW-1:0] f_sat(input logic signed [AW-1:0] v);
        logic signed [CW-1:0] res;
        if (v > L_HI) begin
            res = L_HI[CW-1:0];
        end else if (v < L_LO) begin
            res = L_LO[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    tbb_pkg::t_state r_state, n_state;

    logic signed [tbb_pkg::COEF_W-1:0] r_matrix [16];
    logic signed [tbb_pkg::ORG_W-1:0]  r_org [3];
    logic [XW-1:0]                     r_ext [3];
    logic [2:0]                        r_corner;
    logic [1:0]                        r_row, r_col, r_axis;
    logic signed [CW-1:0]              r_vec [4];
    logic signed [CW-1:0]              r_p [4];
    logic signed [CW-1:0]              r_m [3];
    logic signed [CW-1:0]              r_lo [3];
    logic signed [CW-1:0]              r_hi [3];
    logic signed [PW-1:0]              r_prod;
    logic signed [AW-1:0]              r_acc;
    logic [CW-1:0]                     r_div;
    logic [CW:0]                       r_rem;
    logic [DW-1:0]                     r_quo;
    logic [CNTW-1:0]                   r_cnt;
    logic                              r_wneg;
    logic signed [CW-1:0]              r_rcp;
    logic                              r_out_valid;
    logic signed [OW-1:0]              r_bx, r_by, r_bz;
    logic [SPW-1:0]                    r_bw, r_bh, r_bd;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_mul;
    logic signed [AW-1:0] w_prod_aw;
    logic signed [CW-1:0] w_cs [3];
    logic [CW:0]          w_abs, w_rem_sh, w_rem_nx;
    logic                 w_ge, w_div_last, w_persp, w_out_free;
    logic [AW-1:0]        w_q_aw;
    logic signed [CW-1:0] w_rmag;
    logic signed [SW-1:0] w_span [3];
    logic [SPW-1:0]       w_span_sat [3];

    // shared multiplier: matrix row products, then perspective scaling
    always_comb begin
        if (r_state == tbb_pkg::S_SMUL) begin
            w_ma = MW'(r_p[r_axis]);
            w_mb = MW'(r_rcp);
        end else begin
            w_ma = MW'(r_matrix[{r_row, r_col}]);
            w_mb = MW'(r_vec[r_col]);
        end
    end
    assign w_mul     = w_ma * w_mb;
    assign w_prod_aw = AW'(r_prod);

    // corner coordinates, origin plus selected extents
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_cs[a] = f_sat(AW'(r_org[a]) +
                (r_corner[a] ? $signed({{(AW-XW){1'b0}}, r_ext[a]}) : '0));
        end
    end

    // restoring divider step for the reciprocal of w
    assign w_abs      = r_p[3][CW-1] ? -{r_p[3][CW-1], r_p[3]} : {1'b0, r_p[3]};
    assign w_rem_sh   = {r_rem[CW-1:0], (r_cnt == '0)};
    assign w_ge       = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_nx   = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
    assign w_div_last = (r_cnt == CNTW'(DW - 1));
    assign w_q_aw     = AW'(r_quo);
    assign w_rmag     = (w_q_aw > L_HI) ? L_HI[CW-1:0] : w_q_aw[CW-1:0];
    assign w_persp    = (AW'(r_p[3]) != L_ONE) && (r_p[3] != '0);

    // spans, saturated to the output range
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_span[a]     = SW'(r_hi[a]) - SW'(r_lo[a]);
            w_span_sat[a] = (w_span[a] > L_SPAN_MAX) ? {SPW{1'b1}} : w_span[a][SPW-1:0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and control
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_stat.done = 1'b0;
        o_stat.busy = (r_state != tbb_pkg::S_IDLE);
        unique case (r_state)
            tbb_pkg::S_IDLE: begin
                if (i_q_stat.head_valid) begin
                    o_pop = 1'b1;
                    if (i_head.op == tbb_pkg::OP_BOX) begin
                        n_state = tbb_pkg::S_CORNER;
                    end
                end
            end
            tbb_pkg::S_CORNER: n_state = tbb_pkg::S_MUL;
            tbb_pkg::S_MUL:    n_state = tbb_pkg::S_ACC;
            tbb_pkg::S_ACC: begin
                n_state = (r_col == 2'd3) ? tbb_pkg::S_ROW : tbb_pkg::S_MUL;
            end
            tbb_pkg::S_ROW: begin
                n_state = (r_row == 2'd3) ? tbb_pkg::S_WCHK : tbb_pkg::S_MUL;
            end
            tbb_pkg::S_WCHK: begin
                n_state = w_persp ? tbb_pkg::S_RCP : tbb_pkg::S_BOUND;
            end
            tbb_pkg::S_RCP: begin
                if (w_div_last) begin
                    n_state = tbb_pkg::S_RCPF;
                end
            end
            tbb_pkg::S_RCPF: n_state = tbb_pkg::S_SMUL;
            tbb_pkg::S_SMUL: n_state = tbb_pkg::S_SACC;
            tbb_pkg::S_SACC: begin
                n_state = (r_axis == 2'd2) ? tbb_pkg::S_BOUND : tbb_pkg::S_SMUL;
            end
            tbb_pkg::S_BOUND: begin
                n_state = (r_corner == 3'd7) ? tbb_pkg::S_DONE : tbb_pkg::S_CORNER;
            end
            tbb_pkg::S_DONE: begin
                if (w_out_free) begin
                    o_stat.done = 1'b1;
                    n_state     = tbb_pkg::S_IDLE;
                end
            end
            default: n_state = tbb_pkg::S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // matrix store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_matrix[i] <= (i % 5 == 0) ? tbb_pkg::COEF_W'(f_sat(L_ONE)) : '0;
            end
        end else if (o_pop && i_head.op == tbb_pkg::OP_LOAD) begin
            r_matrix[i_head.idx] <= i_head.coef;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tbb_pkg::S_IDLE: begin
                r_org[0]  <= i_head.org_x;
                r_org[1]  <= i_head.org_y;
                r_org[2]  <= i_head.org_z;
                r_ext[0]  <= i_head.ext_x;
                r_ext[1]  <= i_head.ext_y;
                r_ext[2]  <= i_head.ext_z;
                r_corner  <= 3'd0;
            end
            tbb_pkg::S_CORNER: begin
                for (int a = 0; a < 3; a++) begin
                    r_vec[a] <= w_cs[a];
                end
                r_vec[3] <= f_sat(L_ONE);
                r_row    <= 2'd0;
                r_col    <= 2'd0;
                r_acc    <= '0;
            end
            tbb_pkg::S_MUL: r_prod <= w_mul;
            tbb_pkg::S_ACC: begin
                r_acc <= r_acc + w_prod_aw;
                r_col <= r_col + 2'd1;
            end
            tbb_pkg::S_ROW: begin
                r_p[r_row] <= f_sat(r_acc >>> FRAC_BITS);
                r_acc      <= '0;
                r_row      <= r_row + 2'd1;
            end
            tbb_pkg::S_WCHK: begin
                r_div  <= w_abs[CW-1:0];
                r_wneg <= r_p[3][CW-1];
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_axis <= 2'd0;
                for (int a = 0; a < 3; a++) begin
                    r_m[a] <= r_p[a];
                end
            end
            tbb_pkg::S_RCP: begin
                r_rem <= w_rem_nx;
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + CNTW'(1);
            end
            tbb_pkg::S_RCPF: r_rcp <= r_wneg ? -w_rmag : w_rmag;
            tbb_pkg::S_SMUL: r_prod <= w_mul;
            tbb_pkg::S_SACC: begin
                r_m[r_axis] <= f_sat(w_prod_aw >>> FRAC_BITS);
                r_axis      <= r_axis + 2'd1;
            end
            tbb_pkg::S_BOUND: begin
                for (int a = 0; a < 3; a++) begin
                    if (r_corner == 3'd0 || r_m[a] < r_lo[a]) begin
                        r_lo[a] <= r_m[a];
                    end
                    if (r_corner == 3'd0 || r_m[a] > r_hi[a]) begin
                        r_hi[a] <= r_m[a];
                    end
                end
                r_corner <= r_corner + 3'd1;
            end
            tbb_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_bx <= OW'(r_lo[0]);
                    r_by <= OW'(r_lo[1]);
                    r_bz <= OW'(r_lo[2]);
                    r_bw <= w_span_sat[0];
                    r_bh <= w_span_sat[1];
                    r_bd <= w_span_sat[2];
                end
            end
            default: ;
        endcase
    end

    // result register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bound_x   = r_bx;
    assign o_bound_y   = r_by;
    assign o_bound_z   = r_bz;
    assign o_bound_w   = r_bw;
    assign o_bound_h   = r_bh;
    assign o_bound_d   = r_bd;

endmodule
